// ===== rtl/clt_pkg.sv =====
// ----------------------------------------------------------------------------
// Coordinate lock table package
// Shared widths, operation and status codes, and the request and response
// structs that pass between the top level and the associative store.
// ----------------------------------------------------------------------------
package clt_pkg;

    // Store depth and derived widths
    localparam int LOCK_ENTRIES = 64;
    localparam int CNT_W        = $clog2(LOCK_ENTRIES + 1);

    // Coordinate and key widths
    localparam int X_W      = 16;
    localparam int Y_W      = 12;
    localparam int Z_W      = 16;
    localparam int KEY_W    = X_W + Y_W + Z_W;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int SHOWN_W  = 7;

    // Operation codes; the unused code behaves as a query
    localparam logic [FUNC_W-1:0] FUNC_ACQUIRE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY   = 2'd2;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BUSY     = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOT_HELD = 2'd3
    } status_t;

    // One registered request beat toward the store
    typedef struct packed {
        logic              valid;
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key;
    } req_t;

    // Lookup outcome for the request currently presented
    typedef struct packed {
        logic             hit;
        logic             full;
        logic [CNT_W-1:0] count_next;
    } resp_t;

    // Clamp the lock count to the result field range
    function automatic logic [SHOWN_W-1:0] sat_count(input logic [CNT_W-1:0] c);
        logic [CNT_W+SHOWN_W-1:0] wide;
        wide = {{SHOWN_W{1'b0}}, c};
        if (wide > (CNT_W + SHOWN_W)'((1 << SHOWN_W) - 1)) begin
            return {SHOWN_W{1'b1}};
        end
        return wide[SHOWN_W-1:0];
    endfunction

endpackage

// ===== rtl/clt_cam.sv =====
// ----------------------------------------------------------------------------
// Coordinate lock table associative store
// Holds the lock keys with their valid bits and the held count, compares a
// request key against every entry at once and applies acquire or release.
// ----------------------------------------------------------------------------
module clt_cam
    import clt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  req_t  req,
    output resp_t resp
);

    logic [KEY_W-1:0]        key_reg [LOCK_ENTRIES];
    logic [LOCK_ENTRIES-1:0] valid_reg;
    logic [LOCK_ENTRIES-1:0] valid_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [LOCK_ENTRIES-1:0] match;
    logic [LOCK_ENTRIES-1:0] free;
    logic [LOCK_ENTRIES-1:0] alloc;
    logic                    hit;
    logic                    full;
    logic                    do_acq;
    logic                    do_rel;

    // Compare the request key against every entry
    always_comb
    begin
        for (int i = 0; i < LOCK_ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (key_reg[i] == req.key);
        end
    end

    // Pick the lowest free entry as a one-hot mask
    assign free   = ~valid_reg;
    assign alloc  = free & (~free + LOCK_ENTRIES'(1));
    assign hit    = |match;
    assign full   = ~|free;
    assign do_acq = req.valid && (req.func == FUNC_ACQUIRE) && !hit && !full;
    assign do_rel = req.valid && (req.func == FUNC_RELEASE) && hit;

    // Set the allocated bit on acquire, drop the matched bit on release
    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        if (do_acq)
        begin
            valid_next = valid_reg | alloc;
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rel)
        begin
            valid_next = valid_reg & ~match;
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Hold valid bits and the count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    // Write the key into the allocated entry
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LOCK_ENTRIES; i++)
        begin
            if (do_acq && alloc[i])
            begin
                key_reg[i] <= req.key;
            end
        end
    end

    assign resp.hit        = hit;
    assign resp.full       = full;
    assign resp.count_next = count_next;

endmodule

// ===== rtl/coordinate_lock_table_core.sv =====
// ----------------------------------------------------------------------------
// Coordinate lock table core
// Lock table keyed by 3D cell coordinates with acquire, release and query.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat (func, coord_x, coord_y, coord_z) is taken at a rising edge
//   where start is high and busy is low. busy stays low, so one request may
//   be issued every cycle.
//   The request is registered, looked up against all entries in parallel and
//   applied to the store in the next cycle, where the result is registered.
//   done, status, held and locks_in_use are therefore valid for exactly one
//   cycle, the one that starts at the edge where the store is updated and
//   the result registered. Throughput is one request per cycle; the
//   parallel compare over all entries sets it.
//   Back-to-back requests see each other's effect in order.
//   status: ok, busy (lock already held), full (no free entry) or not held
//   (release of an absent lock). held tells whether the lock was held before
//   the request. locks_in_use is the count after it, clamped to 127.
//   Reset clears all entries and the count at once; no clearing pass.
//   The receiver cannot stall: each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module coordinate_lock_table_core
    import clt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [FUNC_W-1:0]   func,
    input  logic [X_W-1:0]      coord_x,
    input  logic [Y_W-1:0]      coord_y,
    input  logic [Z_W-1:0]      coord_z,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic                held,
    output logic [SHOWN_W-1:0]  locks_in_use
);

    logic               req_valid_reg;
    logic [FUNC_W-1:0]  req_func_reg;
    logic [KEY_W-1:0]   req_key_reg;
    req_t               req;
    resp_t              resp;
    status_t            status_next;
    logic               done_reg;
    status_t            status_reg;
    logic               held_reg;
    logic [SHOWN_W-1:0] shown_reg;

    // Accept a beat every cycle
    assign busy = 1'b0;

    // Register the request beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_func_reg <= func;
            req_key_reg  <= {coord_z, coord_y, coord_x};
        end
    end

    assign req.valid = req_valid_reg;
    assign req.func  = req_func_reg;
    assign req.key   = req_key_reg;

    clt_cam u_cam (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .resp  (resp)
    );

    // Decide the status from the lookup
    always_comb
    begin
        status_next = ST_OK;
        priority if (req_func_reg == FUNC_ACQUIRE)
        begin
            if (resp.hit)
            begin
                status_next = ST_BUSY;
            end
            else if (resp.full)
            begin
                status_next = ST_FULL;
            end
        end
        else if (req_func_reg == FUNC_RELEASE)
        begin
            if (!resp.hit)
            begin
                status_next = ST_NOT_HELD;
            end
        end
        else
        begin
            status_next = ST_OK;
        end
    end

    // Register the result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid_reg)
        begin
            status_reg <= status_next;
            held_reg   <= resp.hit;
            shown_reg  <= sat_count(resp.count_next);
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign held         = held_reg;
    assign locks_in_use = shown_reg;

    // Every registered request yields exactly one result in the next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg == $past(req_valid_reg))
        else $error("result strobe does not follow registered request");

    // Busy answers only for held locks, not-held and full only for absent ones
    a_held_status: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_BUSY) |-> held)
        else $error("busy status without held lock");

    a_unheld_status: assert property (@(posedge clk) disable iff (!rst_n)
        done && ((status == ST_NOT_HELD) || (status == ST_FULL)) |-> !held)
        else $error("not-held or full status with held lock");

    // A full answer means every entry is in use
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_FULL) && (LOCK_ENTRIES < (1 << SHOWN_W))
        |-> (locks_in_use == SHOWN_W'(LOCK_ENTRIES)))
        else $error("full status with free entries");

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Coordinate lock table core testbench
// Drives acquire, release and query beats into the lock table, mirrors the
// held-lock store in a scoreboard model and checks every result beat against
// it: edge coordinates, a fill to capacity and a drain, and mixed random
// traffic over a small pool of keys that share coordinates.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import clt_pkg::*;

    // The spare operation code behaves as a query
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;
    localparam int SHOWN_MAX    = (1 << SHOWN_W) - 1;

    typedef struct {
        status_t            status;
        logic               held;
        logic [SHOWN_W-1:0] in_use;
    } lock_reply_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [FUNC_W-1:0]   func;
    logic [X_W-1:0]      coord_x;
    logic [Y_W-1:0]      coord_y;
    logic [Z_W-1:0]      coord_z;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic                held;
    logic [SHOWN_W-1:0]  locks_in_use;

    // Mirror of the held-lock store
    logic [KEY_W-1:0] held_key [LOCK_ENTRIES];
    bit               held_vld [LOCK_ENTRIES];
    int               held_total;

    lock_reply_t lock_replies_q [$];
    int          sender_idle_pct;
    int          error_count;
    int          cycle_count;

    coordinate_lock_table_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .done         (done),
        .status       (status),
        .held         (held),
        .locks_in_use (locks_in_use)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Apply one request to the mirrored store and return the reply it earns
    function automatic lock_reply_t apply_lock_op(input logic [FUNC_W-1:0] op,
                                                  input logic [KEY_W-1:0] key);
        lock_reply_t r;
        int hit;
        int slot;
        int i;
        hit  = -1;
        slot = -1;
        for (i = 0; i < LOCK_ENTRIES; i++)
        begin
            if (held_vld[i] && held_key[i] == key && hit < 0)
                hit = i;
            if (!held_vld[i] && slot < 0)
                slot = i;
        end
        r.status = ST_OK;
        r.held   = (hit >= 0);
        case (op)
            FUNC_ACQUIRE:
            begin
                if (hit >= 0)
                    r.status = ST_BUSY;
                else if (slot < 0)
                    r.status = ST_FULL;
                else
                begin
                    held_key[slot] = key;
                    held_vld[slot] = 1'b1;
                    held_total++;
                end
            end
            FUNC_RELEASE:
            begin
                if (hit < 0)
                    r.status = ST_NOT_HELD;
                else
                begin
                    held_vld[hit] = 1'b0;
                    held_total--;
                end
            end
            default:
            begin
            end
        endcase
        r.in_use = (held_total > SHOWN_MAX) ? SHOWN_W'(SHOWN_MAX) : SHOWN_W'(held_total);
        return r;
    endfunction

    // Send one request beat, with an optional idle gap ahead of it
    task automatic send_lock_req(input logic [FUNC_W-1:0] op, input logic [X_W-1:0] x,
                                 input logic [Y_W-1:0] y, input logic [Z_W-1:0] z);
        int gap;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            gap = $urandom_range(1, 3);
            start   <= 1'b0;
            func    <= FUNC_W'($urandom_range(3));
            coord_x <= X_W'($urandom);
            coord_y <= Y_W'($urandom);
            coord_z <= Z_W'($urandom);
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        func    <= op;
        coord_x <= x;
        coord_y <= y;
        coord_z <= z;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        lock_replies_q.push_back(apply_lock_op(op, {z, y, x}));
    endtask

    task automatic send_lock_key(input logic [FUNC_W-1:0] op, input logic [KEY_W-1:0] key);
        send_lock_req(op, key[X_W-1:0], key[X_W+Y_W-1:X_W], key[KEY_W-1:X_W+Y_W]);
    endtask

    // Send a request with a random coordinate
    task automatic send_lock_rand(input logic [FUNC_W-1:0] op);
        send_lock_req(op, X_W'($urandom), Y_W'($urandom), Z_W'($urandom));
    endtask

    // Extreme coordinates, every operation and each corner of the protocol
    task automatic test_directed_edges;
        send_lock_req(FUNC_QUERY,   '0, '0, '0);
        send_lock_req(FUNC_RELEASE, '0, '0, '0);
        send_lock_req(FUNC_ACQUIRE, '0, '0, '0);
        send_lock_req(FUNC_ACQUIRE, '1, '1, '1);
        send_lock_req(FUNC_QUERY,   '0, '0, '0);
        send_lock_req(FUNC_QUERY,   '1, '1, '1);
        send_lock_req(FUNC_ACQUIRE, '0, '0, '0);
        // keys that differ from a held one in a single coordinate
        send_lock_req(FUNC_ACQUIRE, '1, '0, '0);
        send_lock_req(FUNC_ACQUIRE, '0, '1, '0);
        send_lock_req(FUNC_ACQUIRE, '0, '0, '1);
        send_lock_req(FUNC_QUERY,   '0, '0, 16'd1);
        send_lock_req(FUNC_SPARE,   '1, '1, '1);
        send_lock_req(FUNC_SPARE,   16'd1, 12'd2, 16'd3);
        send_lock_req(FUNC_RELEASE, '1, '1, '1);
        send_lock_req(FUNC_RELEASE, '1, '1, '1);
        send_lock_req(FUNC_QUERY,   '1, '1, '1);
        send_lock_req(FUNC_RELEASE, '0, '0, '0);
        send_lock_req(FUNC_RELEASE, '1, '0, '0);
        send_lock_req(FUNC_RELEASE, '0, '1, '0);
        send_lock_req(FUNC_RELEASE, '0, '0, '1);
        send_lock_req(FUNC_ACQUIRE, '0, '0, '0);
        send_lock_req(FUNC_RELEASE, '0, '0, '0);
    endtask

    // Fill the store to capacity, hit it while full, then drain it
    task automatic test_fill_and_drain;
        logic [KEY_W-1:0] k;
        int i;
        while (held_total < LOCK_ENTRIES)
            send_lock_rand(FUNC_ACQUIRE);
        repeat (3) send_lock_rand(FUNC_ACQUIRE);
        send_lock_key(FUNC_ACQUIRE, held_key[0]);
        send_lock_key(FUNC_QUERY, held_key[5]);
        send_lock_key(FUNC_SPARE, held_key[LOCK_ENTRIES-1]);
        send_lock_key(FUNC_RELEASE, held_key[3]);
        send_lock_rand(FUNC_ACQUIRE);
        send_lock_rand(FUNC_ACQUIRE);
        // drain, with stray releases and queries mixed in
        for (i = 0; i < LOCK_ENTRIES; i++)
        begin
            if (held_vld[i])
            begin
                k = held_key[i];
                if ($urandom_range(3) == 0)
                    send_lock_rand(FUNC_RELEASE);
                send_lock_key(FUNC_RELEASE, k);
                if ($urandom_range(3) == 0)
                    send_lock_key(FUNC_QUERY, k);
            end
        end
    endtask

    // Random operations over a pool of keys that share coordinates
    task automatic test_mixed_traffic(input int n_beats);
        logic [X_W-1:0]    xs [2];
        logic [Y_W-1:0]    ys [2];
        logic [Z_W-1:0]    zs [2];
        logic [FUNC_W-1:0] op;
        int                pick;
        int                i;
        for (i = 0; i < 2; i++)
        begin
            xs[i] = X_W'($urandom);
            ys[i] = Y_W'($urandom);
            zs[i] = Z_W'($urandom);
        end
        for (i = 0; i < n_beats; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                op = FUNC_ACQUIRE;
            else if (pick < 70)
                op = FUNC_RELEASE;
            else if (pick < 88)
                op = FUNC_QUERY;
            else
                op = FUNC_SPARE;
            if ($urandom_range(99) < 80)
                send_lock_req(op, xs[1'($urandom_range(1))], ys[1'($urandom_range(1))],
                              zs[1'($urandom_range(1))]);
            else
                send_lock_rand(op);
        end
    endtask

    // Compare each result beat with the oldest pending reply
    always @(posedge clk)
    begin
        lock_reply_t want;
        if (rst_n && done)
        begin
            if (lock_replies_q.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("[%0t] unexpected result: status=%0d held=%0b in_use=%0d",
                             $time, status, held, locks_in_use);
            end
            else
            begin
                want = lock_replies_q.pop_front();
                if (status !== want.status || held !== want.held ||
                    locks_in_use !== want.in_use)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                    begin
                        $display("[%0t] mismatch: exp status=%0d held=%0b in_use=%0d",
                                 $time, want.status, want.held, want.in_use);
                        $display("[%0t] mismatch: got status=%0d held=%0b in_use=%0d",
                                 $time, status, held, locks_in_use);
                    end
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int i;
        cycle_count     = 0;
        error_count     = 0;
        held_total      = 0;
        sender_idle_pct = 0;
        for (i = 0; i < LOCK_ENTRIES; i++)
        begin
            held_key[i] = '0;
            held_vld[i] = 1'b0;
        end
        rst_n   <= 1'b0;
        start   <= 1'b0;
        func    <= FUNC_QUERY;
        coord_x <= '0;
        coord_y <= '0;
        coord_z <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct = 10;
        test_directed_edges();
        test_mixed_traffic(120);
        sender_idle_pct = 49;
        test_fill_and_drain();
        sender_idle_pct = 0;
        test_mixed_traffic(150);
        start <= 1'b0;

        // Wait out the pipeline
        while (lock_replies_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/clt_pkg.sv
rtl/clt_cam.sv
rtl/coordinate_lock_table_core.sv
dv/tb_top.sv
